>>> hw/rtl/utt_pkg.sv
// Shared types, constants and helpers for the UTF-16LE to UTF-8 transcoder.
// No dependencies; used by utt_decode, utt_outbuf and the top level.
package utt_pkg;

	localparam longint unsigned MAX_STRING_BYTES = 64'd65536;

	// Offsets saturate at the smaller of MAX_STRING_BYTES - 1 and 0xFFFF
	localparam logic [15:0] POS_LIMIT = (MAX_STRING_BYTES - 64'd1 > 64'd65535) ?
		16'hFFFF : 16'(MAX_STRING_BYTES - 64'd1);

	localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110; // 0xD800..0xDBFF
	localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111; // 0xDC00..0xDFFF
	localparam logic [20:0] SUPP_BASE     = 21'h10000;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_ODD      = 3'd1,
		ST_LONE_LOW = 3'd2,
		ST_HIGH_END = 3'd3,
		ST_NO_LOW   = 3'd4
	} status_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      n;
	} utf8_t;

	// Everything one input word produces: up to four bytes and an optional status
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      nbytes;
		logic            has_status;
		status_t         code;
		logic [15:0]     offset;
	} result_t;

	function automatic utf8_t utf8_encode(input logic [20:0] cp);
		utf8_t r;
		r.bytes = '0;
		if (cp < 21'h80) begin
			r.bytes[0] = cp[7:0];
			r.n = 3'd1;
		end else if (cp < 21'h800) begin
			r.bytes[0] = {3'b110, cp[10:6]};
			r.bytes[1] = {2'b10, cp[5:0]};
			r.n = 3'd2;
		end else if (cp < SUPP_BASE) begin
			r.bytes[0] = {4'b1110, cp[15:12]};
			r.bytes[1] = {2'b10, cp[11:6]};
			r.bytes[2] = {2'b10, cp[5:0]};
			r.n = 3'd3;
		end else begin
			r.bytes[0] = {5'b11110, cp[20:18]};
			r.bytes[1] = {2'b10, cp[17:12]};
			r.bytes[2] = {2'b10, cp[11:6]};
			r.bytes[3] = {2'b10, cp[5:0]};
			r.n = 3'd4;
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/utt_decode.sv
// String state and per-word decode: unit assembly, surrogate pairing, error latch.
// Depends on utt_pkg. Produces the result of the current word combinationally.
module utt_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        in_byte,
	input  logic              last_of_string,
	output utt_pkg::result_t  res
);

	logic [15:0]      pos_q;
	logic [7:0]       held_q;
	logic             half_q;
	logic [15:0]      unit_off_q;
	logic             pend_q;
	logic [9:0]       hb_q;
	logic [15:0]      pend_off_q;
	logic             err_q;
	utt_pkg::status_t err_code_q;
	logic [15:0]      err_off_q;

	logic [15:0]      pos_d;
	logic             half_d;
	logic             pend_d;
	logic [9:0]       hb_d;
	logic [15:0]      pend_off_d;
	logic             err_d;
	utt_pkg::status_t err_code_d;
	logic [15:0]      err_off_d;
	logic [15:0]      unit;
	logic             is_low;
	logic             is_high;
	logic [20:0]      cp;
	utt_pkg::utf8_t   enc;

	assign unit    = {in_byte, held_q};
	assign is_low  = unit[15:10] == utt_pkg::SURR_LOW_TAG;
	assign is_high = unit[15:10] == utt_pkg::SURR_HIGH_TAG;

	always_comb begin
		pos_d      = (pos_q < utt_pkg::POS_LIMIT) ? pos_q + 16'd1 : pos_q;
		half_d     = !half_q;
		pend_d     = pend_q;
		hb_d       = hb_q;
		pend_off_d = pend_off_q;
		err_d      = err_q;
		err_code_d = err_code_q;
		err_off_d  = err_off_q;
		cp         = pend_q ? utt_pkg::SUPP_BASE + 21'({hb_q, unit[9:0]}) : 21'(unit);
		enc        = utt_pkg::utf8_encode(cp);
		res        = '0;
		res.code   = utt_pkg::ST_OK;

		if (half_q && !err_q) begin
			priority if (pend_q) begin
				if (is_low) begin
					pend_d     = 1'b0;
					res.bytes  = enc.bytes;
					res.nbytes = enc.n;
				end else begin
					err_d      = 1'b1;
					err_code_d = utt_pkg::ST_NO_LOW;
					err_off_d  = pend_off_q;
				end
			end else if (is_low) begin
				err_d      = 1'b1;
				err_code_d = utt_pkg::ST_LONE_LOW;
				err_off_d  = unit_off_q;
			end else if (is_high) begin
				pend_d     = 1'b1;
				hb_d       = unit[9:0];
				pend_off_d = unit_off_q;
			end else begin
				res.bytes  = enc.bytes;
				res.nbytes = enc.n;
			end
		end

		if (last_of_string) begin
			res.has_status = 1'b1;
			priority if (half_d) begin
				res.code   = utt_pkg::ST_ODD;
				res.offset = pos_q;
			end else if (err_d) begin
				res.code   = err_code_d;
				res.offset = err_off_d;
			end else if (pend_d) begin
				res.code   = utt_pkg::ST_HIGH_END;
				res.offset = pend_off_d;
			end else begin
				res.code   = utt_pkg::ST_OK;
				res.offset = 16'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			held_q     <= '0;
			half_q     <= 1'b0;
			unit_off_q <= '0;
			pend_q     <= 1'b0;
			hb_q       <= '0;
			pend_off_q <= '0;
			err_q      <= 1'b0;
			err_code_q <= utt_pkg::ST_OK;
			err_off_q  <= '0;
		end else if (accept) begin
			if (last_of_string) begin
				// string closed: back to the idle state for the next one
				pos_q      <= '0;
				held_q     <= '0;
				half_q     <= 1'b0;
				unit_off_q <= '0;
				pend_q     <= 1'b0;
				hb_q       <= '0;
				pend_off_q <= '0;
				err_q      <= 1'b0;
				err_code_q <= utt_pkg::ST_OK;
				err_off_q  <= '0;
			end else begin
				pos_q      <= pos_d;
				half_q     <= half_d;
				pend_q     <= pend_d;
				hb_q       <= hb_d;
				pend_off_q <= pend_off_d;
				err_q      <= err_d;
				err_code_q <= err_code_d;
				err_off_q  <= err_off_d;
				if (!half_q) begin
					held_q     <= in_byte;
					unit_off_q <= pos_q;
				end
			end
		end
	end

endmodule

>>> hw/rtl/utt_outbuf.sv
// Result register and serialiser: holds one word's bytes and status and hands
// them out one per cycle while out_ready is high. Depends on utt_pkg.
module utt_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  utt_pkg::result_t  res,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              is_status,
	output logic [2:0]        status_code,
	output logic [15:0]       error_offset,
	output logic              last
);

	utt_pkg::result_t res_q;
	logic [2:0]       idx_q;
	logic [2:0]       cnt_q;
	logic             load;
	logic             pop;
	logic             final_item;
	logic             byte_item;

	assign out_valid  = idx_q != cnt_q;
	assign final_item = (idx_q + 3'd1) == cnt_q;
	assign pop        = out_valid && out_ready;
	assign in_ready   = !out_valid || (out_ready && final_item);
	assign load       = in_valid && in_ready;

	assign byte_item    = idx_q < res_q.nbytes;
	assign out_byte     = byte_item ? res_q.bytes[idx_q[1:0]] : 8'd0;
	assign is_status    = !byte_item;
	assign last         = !byte_item;
	assign status_code  = byte_item ? 3'(utt_pkg::ST_OK) : 3'(res_q.code);
	assign error_offset = byte_item ? 16'd0 : res_q.offset;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			cnt_q <= '0;
		end else if (load) begin
			idx_q <= '0;
			cnt_q <= res.nbytes + {2'b00, res.has_status};
		end else if (pop) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd5 && idx_q <= cnt_q)
		else $error("item count out of range");

	a_load_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> idx_q == 3'd0)
		else $error("new word did not restart at its first item");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(idx_q))
		else $error("item lost under stall");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !out_valid || (pop && final_item))
		else $error("result register overwritten with items pending");

	a_status_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_status |-> final_item)
		else $error("status is not the final item of a word");

endmodule

>>> hw/rtl/utf16le_to_utf8_transcoder.sv
// UTF-16LE to UTF-8 transcoder, top level.
// Depends on utt_pkg, utt_decode and utt_outbuf.
//
// Usage: feed the string one word (byte) per in_valid/in_ready handshake,
// with last_of_string set on its final byte. Each accepted word is decoded
// in the same cycle against the string state and its results (zero to four
// UTF-8 bytes, plus the status word after the final byte) land in a result
// register. The output channel then hands those out one word per cycle
// while out_ready is high: is_status/last mark the closing status, which
// carries status_code and error_offset. Discard the string's bytes if its
// status is not ok. The first result is valid in the cycle after its
// word's acceptance. The single result register drains one word per cycle
// while out_ready is high; the next input is taken in the cycle the last
// pending result leaves. When the receiver stalls, the pending word holds
// and in_ready drops until it is taken.
// Reset (arst_n low) clears the string state and empties the result
// register; any partly received string is dropped.
module utf16le_to_utf8_transcoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        last_of_string,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        is_status,
	output logic [2:0]  status_code,
	output logic [15:0] error_offset,
	output logic        last
);

	utt_pkg::result_t res;
	logic             accept;

	assign accept = in_valid && in_ready;

	utt_decode u_decode (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.in_byte        (in_byte),
		.last_of_string (last_of_string),
		.res            (res)
	);

	utt_outbuf u_outbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.res          (res),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.is_status    (is_status),
		.status_code  (status_code),
		.error_offset (error_offset),
		.last         (last)
	);

endmodule
